// File: rtl/dkbf_pkg.sv
// Package for the dual-key best-fit store.
// It holds the beat structs, the token and commit structs, and the mode and status codes.
// It has no dependencies.
`default_nettype none

package dkbf_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_TAKE_W = 2'd1;
  localparam logic [1:0] MODE_TAKE_V = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] weight;
    logic signed [31:0] volume;
    logic signed [31:0] min_need;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] box_id;
  } out_t;

  // The search token moves one cell down the chain in each cycle.
  typedef struct packed {
    logic        vld;
    logic [1:0]  mode;
    logic [31:0] need_key;
    logic        found;
    logic [31:0] best_key;
    logic [31:0] best_id;
    logic        free_found;
  } token_t;

  // The commit is broadcast to every cell once the token has left the chain.
  typedef struct packed {
    logic               add_en;
    logic               take_en;
    logic [31:0]        id;
    logic signed [31:0] weight;
    logic signed [31:0] volume;
  } commit_t;

  // This maps a signed value onto an unsigned key with the same order.
  function automatic logic [31:0] order_key(input logic [31:0] x);
    order_key = {~x[31], x[30:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/dkbf_cell.sv
// One cell of the best-fit chain: it holds one box and updates the passing search token.
// It depends on dkbf_pkg.
`default_nettype none

module dkbf_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  dkbf_pkg::token_t      tok_i,
  output dkbf_pkg::token_t      tok_o,
  input  dkbf_pkg::commit_t     commit_i,
  output logic                  claim_o
);
  import dkbf_pkg::*;

  logic        valid_q;
  logic [31:0] weight_q;
  logic [31:0] volume_q;
  logic [31:0] id_q;
  logic        claim_q;
  token_t      tok_q;
  token_t      tok_d;
  logic [31:0] key;
  logic        is_take;
  logic        qualify;
  logic        better;
  logic        claim_here;

  always_comb begin
    key        = (tok_i.mode == MODE_TAKE_V) ? order_key(volume_q) : order_key(weight_q);
    is_take    = (tok_i.mode == MODE_TAKE_W) || (tok_i.mode == MODE_TAKE_V);
    qualify    = tok_i.vld && is_take && valid_q && (key >= tok_i.need_key);
    better     = !tok_i.found || (key < tok_i.best_key) ||
                 ((key == tok_i.best_key) && (id_q > tok_i.best_id));
    claim_here = tok_i.vld && (tok_i.mode == MODE_ADD) && !valid_q && !tok_i.free_found;
    tok_d      = tok_i;
    if (qualify && better) begin
      tok_d.found    = 1'b1;
      tok_d.best_key = key;
      tok_d.best_id  = id_q;
    end
    if (claim_here) begin
      tok_d.free_found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      claim_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.vld) begin
        claim_q <= claim_here;
      end
      if (commit_i.add_en && claim_q) begin
        valid_q <= 1'b1;
      end else if (commit_i.take_en && valid_q && (id_q == commit_i.id)) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i.add_en && claim_q) begin
      weight_q <= commit_i.weight;
      volume_q <= commit_i.volume;
      id_q     <= commit_i.id;
    end
  end

  assign tok_o   = tok_q;
  assign claim_o = claim_q;

endmodule

`default_nettype wire

// File: rtl/dual_key_best_fit_store_top.sv
// Channel  Handshake               Beat
// in       in_valid_i/in_ready_o   in_data_i  (mode, weight, volume, min_need)
// out      out_valid_o/out_ready_i out_data_o (status, box_id)
//
// Each beat sends one token down a chain of CAPACITY cells, one cell per cycle.
// The result is written to the output register when the commit fires after the token has
// left the chain, and a new input beat is taken only once the previous beat has committed.
// A result waits in the output register, and the next input beat is taken while it waits.
// Reset empties the store and clears the identifier counter at once.
// Top level of the dual-key best-fit store. It depends on dkbf_pkg and dkbf_cell.
`default_nettype none

module dual_key_best_fit_store_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  dkbf_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output dkbf_pkg::out_t     out_data_o
);
  import dkbf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e        state_q;
  state_e        state_d;
  in_t           in_q;
  token_t        res_q;
  logic [31:0]   next_id_q;
  logic [31:0]   next_id_d;
  logic          out_valid_q;
  out_t          out_q;
  out_t          out_d;
  logic          in_fire;
  logic          commit_fire;
  commit_t       commit;
  token_t        tok_head;
  token_t        tok [CAPACITY+1];
  logic [CAPACITY-1:0] claim;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign commit_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    tok_head          = '0;
    tok_head.vld      = in_fire;
    tok_head.mode     = in_data_i.mode;
    tok_head.need_key = order_key(in_data_i.min_need);
  end

  assign tok[0] = tok_head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dkbf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1]),
      .commit_i (commit),
      .claim_o  (claim[i])
    );
  end

  always_comb begin
    commit        = '0;
    commit.weight = in_q.weight;
    commit.volume = in_q.volume;
    out_d         = '0;
    out_d.status  = STATUS_NONE;
    next_id_d     = next_id_q;
    unique case (res_q.mode) inside
      MODE_ADD: begin
        if (!res_q.free_found || (next_id_q == ID_MAX)) begin
          out_d.status = STATUS_FULL;
        end else begin
          commit.add_en = commit_fire;
          commit.id     = next_id_q;
          out_d.status  = STATUS_OK;
          out_d.box_id  = next_id_q;
          next_id_d     = next_id_q + 32'd1;
        end
      end
      MODE_TAKE_W, MODE_TAKE_V: begin
        if (res_q.found) begin
          commit.take_en = commit_fire;
          commit.id      = res_q.best_id;
          out_d.status   = STATUS_OK;
          out_d.box_id   = res_q.best_id;
        end
      end
      default: begin
        out_d.status = STATUS_NONE;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_SCAN;
      ST_SCAN: if (tok[CAPACITY].vld) state_d = ST_DONE;
      ST_DONE: if (commit_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit_fire) begin
        next_id_q   <= next_id_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    if (tok[CAPACITY].vld) begin
      res_q <= tok[CAPACITY];
    end
    if (commit_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_one_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(claim))
    else $error("more than one cell claimed the free slot");

  a_no_token_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !tok[CAPACITY].vld)
    else $error("search token left the chain while idle");

  a_add_id_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit.add_en |-> (next_id_q != ID_MAX) && ($countones(claim) == 1))
    else $error("add committed without a free slot or identifier");

  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_fire |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("commit did not return to idle with a result");
`endif

endmodule

`default_nettype wire
